>>> rtl/ycbcr_to_rgb_converter_top_defines.svh
// Assertion macros shared by the YCbCr to RGB converter RTL.
// Uses clk_i and rst_ni of the module that includes this header.
`ifndef YCBCR_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define YCBCR_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define YRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define YRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/yrc_pkg.sv
// Types, constants and helper functions of the YCbCr to RGB converter.
// Self-contained; imported by ycbcr_to_rgb_converter_top.
`default_nettype none

package yrc_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam longint unsigned FULL_SCALE = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam logic [SAMPLE_BITS-1:0] FS_SAMPLE = FULL_SCALE[SAMPLE_BITS-1:0];

  // Studio swing limits in 1/255 of full scale
  localparam longint unsigned STUDIO_LOW  = 16;
  localparam longint unsigned LUMA_HIGH   = 235;
  localparam longint unsigned CHROMA_HIGH = 240;
  localparam longint unsigned LUMA_SPAN   = LUMA_HIGH - STUDIO_LOW;
  localparam longint unsigned CHROMA_SPAN = CHROMA_HIGH - STUDIO_LOW;

  // Stretch datapath: numerator 255*v fits in SAMPLE_BITS+8 bits
  localparam int unsigned WIDE_W      = SAMPLE_BITS + 8;
  localparam int unsigned RECIP_SHIFT = WIDE_W + 8;
  localparam int unsigned RECIP_W     = RECIP_SHIFT - 7;
  localparam int unsigned QUOT_W      = SAMPLE_BITS + 1;
  localparam int unsigned STR_PROD_W  = WIDE_W + RECIP_W;

  localparam logic [WIDE_W-1:0] STUDIO_FOOT = WIDE_W'(STUDIO_LOW * FULL_SCALE);
  localparam logic [WIDE_W-1:0] LUMA_HALF   = WIDE_W'(LUMA_SPAN / 2);
  localparam logic [WIDE_W-1:0] CHROMA_HALF = WIDE_W'(CHROMA_SPAN / 2);

  // ceil(2^k / span): exact floor division for any numerator below 2^WIDE_W
  localparam longint unsigned LUMA_RECIP_L =
    ((64'd1 << RECIP_SHIFT) + LUMA_SPAN - 64'd1) / LUMA_SPAN;
  localparam longint unsigned CHROMA_RECIP_L =
    ((64'd1 << RECIP_SHIFT) + CHROMA_SPAN - 64'd1) / CHROMA_SPAN;
  localparam logic [RECIP_W-1:0] LUMA_RECIP   = LUMA_RECIP_L[RECIP_W-1:0];
  localparam logic [RECIP_W-1:0] CHROMA_RECIP = CHROMA_RECIP_L[RECIP_W-1:0];

  // Matrix datapath
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned C2_W     = SAMPLE_BITS + 2;
  localparam int unsigned PROD_W   = COEF_W + 1 + C2_W;
  localparam int unsigned ACC_FRAC = 17;
  localparam int unsigned ACC_W    = SAMPLE_BITS + 22;
  localparam int unsigned RND_W    = ACC_W - ACC_FRAC;

  localparam int unsigned NUM_LANES   = 3;
  localparam int unsigned LANE_LUMA   = 0;
  localparam int unsigned LANE_CB     = 1;
  localparam int unsigned LANE_CR     = 2;
  localparam int unsigned PIPE_DEPTH  = 6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = COEF_W;

  localparam logic [COEF_W-1:0] CR_TO_RED_RST   = COEF_W'(91881);
  localparam logic [COEF_W-1:0] CB_TO_BLUE_RST  = COEF_W'(116130);
  localparam logic [COEF_W-1:0] CR_TO_GREEN_RST = COEF_W'(46802);
  localparam logic [COEF_W-1:0] CB_TO_GREEN_RST = COEF_W'(22554);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWING_ENABLE = 3'd0,
    CFG_CR_TO_RED    = 3'd1,
    CFG_CB_TO_BLUE   = 3'd2,
    CFG_CR_TO_GREEN  = 3'd3,
    CFG_CB_TO_GREEN  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] luma;
    logic [SAMPLE_BITS-1:0] chroma_blue;
    logic [SAMPLE_BITS-1:0] chroma_red;
    logic [SAMPLE_BITS-1:0] alpha_in;
  } ycc_pixel_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] red;
    logic [SAMPLE_BITS-1:0] green;
    logic [SAMPLE_BITS-1:0] blue;
    logic [SAMPLE_BITS-1:0] alpha_out;
  } rgb_pixel_t;

  function automatic logic [WIDE_W-1:0] lane_half(input logic is_luma);
    return is_luma ? LUMA_HALF : CHROMA_HALF;
  endfunction

  function automatic logic [RECIP_W-1:0] lane_recip(input logic is_luma);
    return is_luma ? LUMA_RECIP : CHROMA_RECIP;
  endfunction

  // Round half up from 2^-17 sample units, clamp to 0..full scale
  function automatic logic [SAMPLE_BITS-1:0] settle(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] sum;
    logic [RND_W-1:0] rnd;
    sum = acc + (ACC_W'(1) << (ACC_FRAC - 1));
    rnd = sum[ACC_W-1:ACC_FRAC];
    if (acc[ACC_W-1]) begin
      return '0;
    end else if (rnd > RND_W'(FS_SAMPLE)) begin
      return FS_SAMPLE;
    end
    return rnd[SAMPLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/ycbcr_to_rgb_converter_top.sv
// YCbCr to RGB converter, six-stage pipeline; uses yrc_pkg and the assertion
// macros in ycbcr_to_rgb_converter_top_defines.svh.
//
// Input channel: an item (pixel_i) is taken at a rising edge with start high and
// busy low. busy is high only from reset until the first clock edge after it,
// so a new item may enter in every cycle.
// Output channel: each result item shows on rgb_o for exactly one cycle with
// out_valid_o high, once it has passed all six pipeline registers, in input order.
// The receiver cannot hold results off, and none is needed: the pipeline never
// stalls, so throughput is one item per cycle.
// Stages: studio-swing numerator, reciprocal multiply (divide by 219 or 224),
// clamp (raw sample if swing is off), chroma centering with the four 19x18 matrix
// multiplies, the sums, then rounding and clamping into the output register.
// Configuration: cfg_we_i writes cfg_data_i into the register picked by
// cfg_idx_i; unknown indexes are ignored. Write only while no item is in
// flight. Reset restores the default coefficients and clears swing_enable
// and all valid bits.
`default_nettype none
`include "ycbcr_to_rgb_converter_top_defines.svh"

module ycbcr_to_rgb_converter_top
  import yrc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire ycc_pixel_t            pixel_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output      logic                  out_valid_o,
  output      rgb_pixel_t            rgb_o
);

  // ---------------------------------------------------------------- control
  logic                  busy_q;
  logic                  in_accept;
  logic [PIPE_DEPTH-1:0] valid_q, valid_d;

  assign in_accept = start && !busy_q;
  assign valid_d   = {valid_q[PIPE_DEPTH-2:0], in_accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      valid_q <= '0;
    end else begin
      busy_q  <= 1'b0;
      valid_q <= valid_d;
    end
  end

  assign busy        = busy_q;
  assign out_valid_o = valid_q[PIPE_DEPTH-1];

  // ---------------------------------------------------------- configuration
  logic              swing_q;
  logic [COEF_W-1:0] cr_to_red_q, cb_to_blue_q, cr_to_green_q, cb_to_green_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swing_q       <= 1'b0;
      cr_to_red_q   <= CR_TO_RED_RST;
      cb_to_blue_q  <= CB_TO_BLUE_RST;
      cr_to_green_q <= CR_TO_GREEN_RST;
      cb_to_green_q <= CB_TO_GREEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SWING_ENABLE: swing_q       <= cfg_data_i[0];
        CFG_CR_TO_RED:    cr_to_red_q   <= cfg_data_i;
        CFG_CB_TO_BLUE:   cb_to_blue_q  <= cfg_data_i;
        CFG_CR_TO_GREEN:  cr_to_green_q <= cfg_data_i;
        CFG_CB_TO_GREEN:  cb_to_green_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- alpha and swing
  logic [SAMPLE_BITS-1:0] alpha_q [PIPE_DEPTH-1];
  logic [1:0]             swing_pipe_q;

  always_ff @(posedge clk_i) begin
    alpha_q[0]   <= pixel_i.alpha_in;
    swing_pipe_q <= {swing_pipe_q[0], swing_q};
    for (int i = 1; i < PIPE_DEPTH - 1; i++) begin
      alpha_q[i] <= alpha_q[i-1];
    end
  end

  // ------------------------------------------------ stages 1 to 3 per lane
  logic [SAMPLE_BITS-1:0] lane_in [NUM_LANES];
  logic [SAMPLE_BITS-1:0] s3_smp_q [NUM_LANES];

  assign lane_in[LANE_LUMA] = pixel_i.luma;
  assign lane_in[LANE_CB]   = pixel_i.chroma_blue;
  assign lane_in[LANE_CR]   = pixel_i.chroma_red;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    localparam logic IS_LUMA = (l == LANE_LUMA);

    logic [WIDE_W-1:0]      up;
    logic [WIDE_W-1:0]      s1_num_q, s1_num_d;
    logic [SAMPLE_BITS-1:0] s1_raw_q, s2_raw_q;
    logic [STR_PROD_W-1:0]  prod;
    logic [QUOT_W-1:0]      s2_quot_q, s2_quot_d;
    logic [SAMPLE_BITS-1:0] s3_smp_d;

    // Stage 1: 255*v - 16*FS + span/2, zero when in the foot room
    always_comb begin
      up = {lane_in[l], 8'b0} - {8'b0, lane_in[l]};
      if (up <= STUDIO_FOOT) begin
        s1_num_d = '0;
      end else begin
        s1_num_d = up - STUDIO_FOOT + lane_half(IS_LUMA);
      end
    end

    // Stage 2: divide by the span through the reciprocal
    always_comb begin
      prod      = STR_PROD_W'(s1_num_q) * STR_PROD_W'(lane_recip(IS_LUMA));
      s2_quot_d = prod[RECIP_SHIFT +: QUOT_W];
    end

    // Stage 3: clamp the stretched value, or pass the raw sample
    always_comb begin
      if (!swing_pipe_q[1]) begin
        s3_smp_d = s2_raw_q;
      end else if (s2_quot_q > QUOT_W'(FS_SAMPLE)) begin
        s3_smp_d = FS_SAMPLE;
      end else begin
        s3_smp_d = s2_quot_q[SAMPLE_BITS-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      s1_num_q    <= s1_num_d;
      s1_raw_q    <= lane_in[l];
      s2_quot_q   <= s2_quot_d;
      s2_raw_q    <= s1_raw_q;
      s3_smp_q[l] <= s3_smp_d;
    end
  end

  // ------------------------------------- stage 4: centre chroma, multiply
  logic signed [C2_W-1:0]   cb2, cr2;
  logic signed [PROD_W-1:0] s4_pr_q, s4_pb_q, s4_pgr_q, s4_pgb_q;
  logic signed [PROD_W-1:0] s4_pr_d, s4_pb_d, s4_pgr_d, s4_pgb_d;
  logic [SAMPLE_BITS-1:0]   s4_y_q;

  always_comb begin
    cb2 = $signed({1'b0, s3_smp_q[LANE_CB], 1'b0}) - $signed({2'b00, FS_SAMPLE});
    cr2 = $signed({1'b0, s3_smp_q[LANE_CR], 1'b0}) - $signed({2'b00, FS_SAMPLE});
    s4_pr_d  = $signed({1'b0, cr_to_red_q})   * cr2;
    s4_pb_d  = $signed({1'b0, cb_to_blue_q})  * cb2;
    s4_pgr_d = $signed({1'b0, cr_to_green_q}) * cr2;
    s4_pgb_d = $signed({1'b0, cb_to_green_q}) * cb2;
  end

  always_ff @(posedge clk_i) begin
    s4_pr_q  <= s4_pr_d;
    s4_pb_q  <= s4_pb_d;
    s4_pgr_q <= s4_pgr_d;
    s4_pgb_q <= s4_pgb_d;
    s4_y_q   <= s3_smp_q[LANE_LUMA];
  end

  // ------------------------------------------------------ stage 5: sums
  logic signed [ACC_W-1:0] yacc;
  logic signed [ACC_W-1:0] s5_racc_q, s5_gacc_q, s5_bacc_q;
  logic signed [ACC_W-1:0] s5_racc_d, s5_gacc_d, s5_bacc_d;

  always_comb begin
    yacc = $signed({{(ACC_W-SAMPLE_BITS-ACC_FRAC){1'b0}}, s4_y_q, {ACC_FRAC{1'b0}}});
    s5_racc_d = yacc + ACC_W'(s4_pr_q);
    s5_bacc_d = yacc + ACC_W'(s4_pb_q);
    s5_gacc_d = yacc - ACC_W'(s4_pgr_q) - ACC_W'(s4_pgb_q);
  end

  always_ff @(posedge clk_i) begin
    s5_racc_q <= s5_racc_d;
    s5_gacc_q <= s5_gacc_d;
    s5_bacc_q <= s5_bacc_d;
  end

  // -------------------------------------------- stage 6: round and clamp
  rgb_pixel_t rgb_q, rgb_d;

  always_comb begin
    rgb_d.red       = settle(s5_racc_q);
    rgb_d.green     = settle(s5_gacc_q);
    rgb_d.blue      = settle(s5_bacc_q);
    rgb_d.alpha_out = alpha_q[PIPE_DEPTH-2];
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign rgb_o = rgb_q;

  // ------------------------------------------------------------ assertions
  `YRC_ASSERT_IMP(a_latency, 1'b1,
    out_valid_o == $past(in_accept, PIPE_DEPTH),
    "result strobe out of step with accepted items")
  `YRC_ASSERT_IMP(a_alpha_through, out_valid_o,
    rgb_o.alpha_out == $past(pixel_i.alpha_in, PIPE_DEPTH),
    "alpha not carried through")
  `YRC_ASSERT_NEXT(a_red_floor, valid_q[PIPE_DEPTH-2] && s5_racc_q[ACC_W-1],
    rgb_o.red == '0,
    "negative red sum not floored")

endmodule

`default_nettype wire

>>> bench/tb_ycbcr_to_rgb_converter_top.sv
// Testbench for ycbcr_to_rgb_converter_top: random and directed pixels checked
// against a cycle-free model of the color conversion, under several register settings.
// Depends on yrc_pkg and the converter RTL only.
`default_nettype none

module tb_ycbcr_to_rgb_converter_top
  import yrc_pkg::*;
();

  localparam int unsigned LIMIT_CYCLES = 100000;
  localparam int unsigned RANDOM_PER_PHASE = 140;
  localparam logic [COEF_W-1:0] COEF_MAX = '1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  ycc_pixel_t            pixel_i = '0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  out_valid_o;
  rgb_pixel_t            rgb_o;

  ycbcr_to_rgb_converter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pixel_i    (pixel_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .rgb_o      (rgb_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the conversion registers
  logic              swing_on  = 1'b0;
  logic [COEF_W-1:0] k_cr_red  = CR_TO_RED_RST;
  logic [COEF_W-1:0] k_cb_blue = CB_TO_BLUE_RST;
  logic [COEF_W-1:0] k_cr_grn  = CR_TO_GREEN_RST;
  logic [COEF_W-1:0] k_cb_grn  = CB_TO_GREEN_RST;

  ycc_pixel_t pending_pixels[$];
  rgb_pixel_t expected_rgb[$];
  bit         idle_en = 1'b1;
  int         errors = 0;
  int unsigned cycles = 0;

  // Strip studio foot and head room, rounding half up
  function automatic longint unsigned unstudio(longint unsigned v, longint unsigned span);
    longint unsigned up;
    longint unsigned foot;
    longint unsigned q;
    up = 255 * v;
    foot = STUDIO_LOW * FULL_SCALE;
    if (up <= foot) begin
      return 0;
    end
    q = (up - foot + span / 2) / span;
    return (q > FULL_SCALE) ? FULL_SCALE : q;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] round_clamp(longint acc);
    longint r;
    if (acc < 0) begin
      return '0;
    end
    r = (acc + (longint'(1) << (ACC_FRAC - 1))) >>> ACC_FRAC;
    return (r > longint'(FULL_SCALE)) ? FS_SAMPLE : r[SAMPLE_BITS-1:0];
  endfunction

  function automatic rgb_pixel_t convert_pixel(ycc_pixel_t px);
    longint unsigned y;
    longint unsigned cb;
    longint unsigned cr;
    longint cb2;
    longint cr2;
    longint yacc;
    rgb_pixel_t res;
    y = px.luma;
    cb = px.chroma_blue;
    cr = px.chroma_red;
    if (swing_on) begin
      y = unstudio(y, LUMA_SPAN);
      cb = unstudio(cb, CHROMA_SPAN);
      cr = unstudio(cr, CHROMA_SPAN);
    end
    cb2 = longint'(2 * cb) - longint'(FULL_SCALE);
    cr2 = longint'(2 * cr) - longint'(FULL_SCALE);
    yacc = longint'(y) <<< ACC_FRAC;
    res.red = round_clamp(yacc + longint'(k_cr_red) * cr2);
    res.green = round_clamp(yacc - longint'(k_cr_grn) * cr2 - longint'(k_cb_grn) * cb2);
    res.blue = round_clamp(yacc + longint'(k_cb_blue) * cb2);
    res.alpha_out = px.alpha_in;
    return res;
  endfunction

  // Bias samples toward the studio limits, the chroma center and the rails
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0: return SAMPLE_BITS'($urandom_range(4200));
      1: return SAMPLE_BITS'($urandom_range(65535, 60000));
      2: return SAMPLE_BITS'($urandom_range(32800, 32736));
      3: return ($urandom_range(1)) ? FS_SAMPLE : '0;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Driver: present queued items, idle at random
  always @(posedge clk_i) begin
    logic       taken;
    logic       nxt_start;
    ycc_pixel_t nxt_pixel;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      nxt_start = start;
      nxt_pixel = pixel_i;
      if (taken) begin
        expected_rgb.push_back(convert_pixel(pixel_i));
      end
      if (!start || taken) begin
        nxt_start = 1'b0;
        if (pending_pixels.size() > 0 && !(idle_en && $urandom_range(99) < 25)) begin
          nxt_pixel = pending_pixels.pop_front();
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
      pixel_i <= nxt_pixel;
    end
  end

  // Monitor: every strobed result must match the oldest expectation
  always @(posedge clk_i) begin
    rgb_pixel_t want;
    string      lane_name [4];
    lane_name = '{"red", "green", "blue", "alpha"};
    if (rst_ni && out_valid_o) begin
      if (expected_rgb.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, rgb_o);
      end else begin
        want = expected_rgb.pop_front();
        for (int f = 0; f < 4; f++) begin
          if (rgb_o[63-16*f -: 16] !== want[63-16*f -: 16]) begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, lane_name[f],
                     want[63-16*f -: 16], rgb_o[63-16*f -: 16]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_ycbcr_to_rgb_converter_top: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (!(pending_pixels.size() == 0 && !start && expected_rgb.size() == 0));
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (cfg_idx_e'(idx))
      CFG_SWING_ENABLE: swing_on = data[0];
      CFG_CR_TO_RED:    k_cr_red = data;
      CFG_CB_TO_BLUE:   k_cb_blue = data;
      CFG_CR_TO_GREEN:  k_cr_grn = data;
      CFG_CB_TO_GREEN:  k_cb_grn = data;
      default: ;
    endcase
  endtask

  // Write all registers plus one unmapped index, then drop the write enable
  task automatic apply_settings(logic sw, logic [COEF_W-1:0] cr_r, logic [COEF_W-1:0] cb_b,
                                logic [COEF_W-1:0] cr_g, logic [COEF_W-1:0] cb_g);
    wait_drained();
    put_reg(CFG_SWING_ENABLE, {(CFG_DATA_W-1)'($urandom), sw});
    put_reg(CFG_CR_TO_RED, cr_r);
    put_reg(CFG_CB_TO_BLUE, cb_b);
    put_reg(CFG_CR_TO_GREEN, cr_g);
    put_reg(CFG_CB_TO_GREEN, cb_g);
    put_reg(CFG_IDX_W'($urandom_range(7, 5)), CFG_DATA_W'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_pixel(logic [15:0] y, logic [15:0] cb, logic [15:0] cr, logic [15:0] a);
    ycc_pixel_t px;
    px.luma = y;
    px.chroma_blue = cb;
    px.chroma_red = cr;
    px.alpha_in = a;
    pending_pixels.push_back(px);
  endtask

  task automatic push_corners();
    push_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h5555);
    push_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 16'hAAAA);
    push_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_pixel(16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001);
    // studio foot, just above it, luma head, chroma head, past the head
    push_pixel(16'd4112, 16'd4112, 16'd4112, 16'hFFFE);
    push_pixel(16'd4113, 16'd4113, 16'd4113, 16'h1234);
    push_pixel(16'd60395, 16'd61680, 16'd61680, 16'hFEDC);
    push_pixel(16'd60396, 16'd61681, 16'd32768, 16'h0F0F);
    push_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'hF0F0);
    push_pixel(16'h5555, 16'hAAAA, 16'h5555, 16'h0000);
  endtask

  initial begin
    ycc_pixel_t px;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners with the reset coefficients, then with studio swing
    push_corners();
    apply_settings(1'b1, CR_TO_RED_RST, CB_TO_BLUE_RST, CR_TO_GREEN_RST, CB_TO_GREEN_RST);
    push_corners();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_settings(1'b0, 18'd103206, 18'd121609, 18'd30679, 18'd12276);
        1: apply_settings(1'b1, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        2: apply_settings(1'b0, '0, '0, '0, '0);
        3: apply_settings(1'b1, COEF_W'($urandom), COEF_W'($urandom),
                          COEF_W'($urandom), COEF_W'($urandom));
        4: apply_settings(1'b0, COEF_W'($urandom), COEF_W'($urandom),
                          COEF_W'($urandom), COEF_W'($urandom));
        default: apply_settings(1'b1, CR_TO_RED_RST, CB_TO_BLUE_RST,
                                CR_TO_GREEN_RST, CB_TO_GREEN_RST);
      endcase
      // one phase runs back to back with no idle cycles
      idle_en = (ph != 3);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        px.luma = pick_sample();
        px.chroma_blue = pick_sample();
        px.chroma_red = pick_sample();
        px.alpha_in = SAMPLE_BITS'($urandom);
        pending_pixels.push_back(px);
      end
    end

    wait_drained();
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_ycbcr_to_rgb_converter_top: done, clean");
    end else begin
      $display("tb_ycbcr_to_rgb_converter_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
